>>> hw/rtl/crsf_rc_channel_receiver_assert.svh
// assertion macros used by the receiver top module
`ifndef CRSF_RC_CHANNEL_RECEIVER_ASSERT_SVH
`define CRSF_RC_CHANNEL_RECEIVER_ASSERT_SVH
`ifndef SYNTH
`define CRSF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crsf assertion failed");
`define CRSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crsf assertion failed");
`else
`define CRSF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRSF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/crsf_pkg.sv
package crsf_pkg;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [7:0] ADDR_FC = 8'hC8;
    localparam logic [7:0] ADDR_TX = 8'hEA;
    localparam logic [7:0] ADDR_BCAST = 8'h00;
    localparam logic [7:0] RC_TYPE = 8'h16;
    localparam logic [7:0] RC_LEN = 8'd24;
    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam logic [10:0] RAW_MIN = 11'd172;
    localparam logic [10:0] RAW_MAX = 11'd1811;
    localparam logic [10:0] US_BASE = 11'd1000;
    localparam logic [10:0] US_INIT = 11'd1500;
    localparam logic [20:0] RAW_SPAN = 21'd1639;
    localparam logic [20:0] US_SPAN = 21'd1000;
    localparam logic [21:0] RECIP = 22'(64'd4294967296 / 64'd1639);
    localparam logic [8:0] GAIN_ONE = 9'd256;
    localparam logic [4:0] CH_BITS = 5'd11;
    localparam logic [3:0] CH_LAST = 4'd15;
    localparam logic [7:0] CFG_ALPHA = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT = 8'd1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        P_ADDR,
        P_LEN,
        P_BODY
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_FETCH,
        C_LOAD,
        C_CLAMP,
        C_RECIP,
        C_CORR,
        C_US,
        C_F1A,
        C_F1B,
        C_F2A,
        C_F2B,
        C_OUT
    } chan_state_t;

    typedef struct packed {
        logic        valid;
        logic [3:0]  index;
        logic [10:0] raw;
        logic [10:0] us;
        logic        last;
    } res_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crsf_ram.sv
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/crsf_parser.sv
module crsf_parser #(
    parameter int MAX_FRAME = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_valid,
    input  logic [7:0]                   rx_byte,
    output logic                         wr_en,
    output logic [$clog2(MAX_FRAME)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic                         frame_good
);
    import crsf_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME - 2);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] type_reg, type_next;
    logic       last_byte;

    assign last_byte = (pos_reg + 8'd1) == len_reg;

    always_comb begin
        phase_next = phase_reg;
        if (byte_valid) begin
            unique case (phase_reg)
                P_LEN: begin
                    phase_next = (rx_byte < LEN_MIN || rx_byte > LEN_MAX) ? P_ADDR : P_BODY;
                end
                P_BODY: begin
                    if (last_byte) begin
                        phase_next = P_ADDR;
                    end
                end
                default: begin
                    phase_next = (rx_byte == ADDR_FC || rx_byte == ADDR_TX ||
                                  rx_byte == ADDR_BCAST) ? P_LEN : P_ADDR;
                end
            endcase
        end
    end

    always_comb begin
        len_next = len_reg;
        pos_next = pos_reg;
        crc_next = crc_reg;
        type_next = type_reg;
        wr_en = 1'b0;
        frame_good = 1'b0;
        if (byte_valid) begin
            unique case (phase_reg)
                P_LEN: begin
                    len_next = rx_byte;
                    pos_next = 8'd0;
                    crc_next = 8'd0;
                end
                P_BODY: begin
                    wr_en = 1'b1;
                    pos_next = pos_reg + 8'd1;
                    if (pos_reg == 8'd0) begin
                        type_next = rx_byte;
                    end
                    if (!last_byte) begin
                        crc_next = crc8_byte(crc_reg, rx_byte);
                    end else begin
                        frame_good = (len_reg == RC_LEN) && (crc_reg == rx_byte) &&
                                     (type_reg == RC_TYPE);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign wr_addr = pos_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_ADDR;
            len_reg <= 8'd0;
            pos_reg <= 8'd0;
            crc_reg <= 8'd0;
            type_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            len_reg <= len_next;
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            type_reg <= type_next;
        end
    end
endmodule

>>> hw/rtl/crsf_chan.sv
module crsf_chan #(
    parameter int MAX_FRAME = 64,
    parameter int FRAC = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [8:0]                   alpha,
    input  logic                         out_free,
    output logic [$clog2(MAX_FRAME)-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    output crsf_pkg::res_t               res,
    output logic                         busy
);
    import crsf_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int FW = 11 + FRAC;
    localparam int PW = FW + 10;
    localparam logic [FW-1:0] F_INIT = FW'(US_INIT) << FRAC;
    localparam logic [FW-1:0] F_HALF = FW'(1) << (FRAC - 1);

    chan_state_t state_reg, state_next;
    logic [AW-1:0]   ba_reg, ba_next;
    logic [17:0]     acc_reg, acc_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [3:0]      ch_reg, ch_next;
    logic [10:0]     raw_reg, raw_next;
    logic [20:0]     x_reg, x_next;
    logic [42:0]     p_reg, p_next;
    logic [10:0]     q_reg, q_next;
    logic [20:0]     r_reg, r_next;
    logic [10:0]     us_reg, us_next;
    logic [FW-1:0]   f1_reg, f1_next, f2_reg, f2_next;
    logic [FW-1:0]   f1n_reg, f1n_next, f2n_reg, f2n_next;
    logic [PW-1:0]   t_reg, t_next;
    logic [15:0]     vld_reg, vld_next;
    logic [8:0]      a, a2;
    logic [10:0]     v;
    logic [2*FW-1:0] frd;
    logic            fwe;

    assign a = alpha[8] ? GAIN_ONE : alpha;
    assign a2 = a[8] || a[7] ? GAIN_ONE : {a[7:0], 1'b0};

    crsf_ram #(.WIDTH(2 * FW), .DEPTH(16)) u_filt (
        .aclk  (aclk),
        .we    (fwe),
        .waddr (ch_reg),
        .wdata ({f2n_reg, f1n_reg}),
        .raddr (ch_reg),
        .rdata (frd)
    );

    assign rd_addr = ba_reg;
    assign busy = state_reg != C_IDLE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (start) state_next = C_FETCH;
            C_FETCH: state_next = C_LOAD;
            C_LOAD:  state_next = (cnt_reg + 5'd8 >= CH_BITS) ? C_CLAMP : C_FETCH;
            C_CLAMP: state_next = C_RECIP;
            C_RECIP: state_next = C_CORR;
            C_CORR:  state_next = C_US;
            C_US:    state_next = C_F1A;
            C_F1A:   state_next = C_F1B;
            C_F1B:   state_next = C_F2A;
            C_F2A:   state_next = C_F2B;
            C_F2B:   state_next = C_OUT;
            C_OUT: begin
                if (out_free) begin
                    if (ch_reg == CH_LAST) begin
                        state_next = C_IDLE;
                    end else begin
                        state_next = (cnt_reg >= CH_BITS) ? C_CLAMP : C_FETCH;
                    end
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        ba_next = ba_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        ch_next = ch_reg;
        raw_next = raw_reg;
        x_next = x_reg;
        p_next = p_reg;
        q_next = q_reg;
        r_next = r_reg;
        us_next = us_reg;
        f1_next = f1_reg;
        f2_next = f2_reg;
        f1n_next = f1n_reg;
        f2n_next = f2n_reg;
        t_next = t_reg;
        vld_next = vld_reg;
        fwe = 1'b0;
        v = acc_reg[10:0];
        if (v < RAW_MIN) v = RAW_MIN;
        if (v > RAW_MAX) v = RAW_MAX;
        res = '0;
        unique case (state_reg)
            C_IDLE: begin
                ba_next = AW'(1);
                acc_next = '0;
                cnt_next = '0;
                ch_next = '0;
            end
            C_LOAD: begin
                acc_next = acc_reg | (18'(rd_data) << cnt_reg);
                cnt_next = cnt_reg + 5'd8;
                ba_next = ba_reg + AW'(1);
            end
            C_CLAMP: begin
                raw_next = acc_reg[10:0];
                x_next = (21'(v) - 21'(RAW_MIN)) * US_SPAN;
                acc_next = acc_reg >> CH_BITS;
                cnt_next = cnt_reg - CH_BITS;
            end
            C_RECIP: p_next = 43'(x_reg) * 43'(RECIP);
            C_CORR: begin
                q_next = p_reg[42:32];
                r_next = x_reg - 21'(p_reg[42:32]) * RAW_SPAN;
            end
            C_US: begin
                us_next = US_BASE + q_reg + 11'(r_reg >= RAW_SPAN);
                f1_next = vld_reg[ch_reg] ? frd[FW-1:0] : F_INIT;
                f2_next = vld_reg[ch_reg] ? frd[2*FW-1:FW] : F_INIT;
            end
            C_F1A: t_next = PW'(f1_reg) * PW'(GAIN_ONE - a);
            C_F1B: f1n_next = FW'((t_reg + (PW'(us_reg) << FRAC) * PW'(a) + PW'(128)) >> 8);
            C_F2A: t_next = PW'(f2_reg) * PW'(GAIN_ONE - a2);
            C_F2B: f2n_next = FW'((t_reg + PW'(f1n_reg) * PW'(a2) + PW'(128)) >> 8);
            C_OUT: begin
                if (out_free) begin
                    res.valid = 1'b1;
                    res.index = ch_reg;
                    res.raw = raw_reg;
                    res.us = 11'((f2n_reg + F_HALF) >> FRAC);
                    res.last = ch_reg == CH_LAST;
                    fwe = 1'b1;
                    vld_next[ch_reg] = 1'b1;
                    ch_next = ch_reg + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            vld_reg <= '0;
        end else begin
            state_reg <= state_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        ba_reg <= ba_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
        ch_reg <= ch_next;
        raw_reg <= raw_next;
        x_reg <= x_next;
        p_reg <= p_next;
        q_reg <= q_next;
        r_reg <= r_next;
        us_reg <= us_next;
        f1_reg <= f1_next;
        f2_reg <= f2_next;
        f1n_reg <= f1n_next;
        f2n_reg <= f2n_next;
        t_reg <= t_next;
    end
endmodule

>>> hw/rtl/crsf_rc_channel_receiver.sv
// latency: a status query shows its word on the cycle after it is taken
// a good rc frame gives 16 words through the channel sequencer
// one or two frame-buffer reads per channel, then the compute states from clamp to out, at most one multiply per cycle
// throughput: one input word per cycle while idle, none taken during a channel run
// or while a word waits on the output
// reset: synchronous active-low, filter state reads as 1500 until first written
module crsf_rc_channel_receiver #(
    parameter int MAX_FRAME = 64,
    parameter int FILTER_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rx_byte, now_ms
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // channel_index, channel_raw, channel_us, link_alive, frame_count
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import crsf_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);

    logic [8:0]  alpha_reg;
    logic [31:0] tmo_reg, last_time_reg, frames_reg;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_kind_reg, m_kind_next, m_last_reg, m_last_next;
    logic        in_acc, byte_acc, query, good, busy, out_free, alive;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;
    res_t        res;

    assign cfg_ready = 1'b1;
    assign s_tready = !busy && !m_valid_reg;
    assign in_acc = s_tvalid && s_tready;
    assign byte_acc = in_acc && !s_tuser;
    assign query = in_acc && s_tuser;
    assign out_free = !m_valid_reg || m_tready;
    assign alive = (frames_reg != 32'd0) && ((s_tdata[39:8] - last_time_reg) < tmo_reg);

    crsf_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_acc),
        .rx_byte    (s_tdata[7:0]),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .frame_good (good)
    );

    crsf_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    crsf_chan #(.MAX_FRAME(MAX_FRAME), .FRAC(FILTER_FRAC_BITS)) u_chan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (good),
        .alpha    (alpha_reg),
        .out_free (out_free),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res      (res),
        .busy     (busy)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_kind_next = m_kind_reg;
        m_last_next = m_last_reg;
        if (query) begin
            m_valid_next = 1'b1;
            m_kind_next = KIND_STATUS;
            m_last_next = 1'b1;
            m_data_next = {5'd0, frames_reg, alive, 26'd0};
        end else if (res.valid) begin
            m_valid_next = 1'b1;
            m_kind_next = KIND_CHANNEL;
            m_last_next = res.last;
            m_data_next = {5'd0, 32'd0, 1'b0, res.us, res.raw, res.index};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            alpha_reg <= 9'd64;
            tmo_reg <= 32'd500;
            last_time_reg <= 32'd0;
            frames_reg <= 32'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_index == CFG_ALPHA) begin
                alpha_reg <= cfg_data[8:0];
            end
            if (cfg_valid && cfg_index == CFG_TIMEOUT) begin
                tmo_reg <= cfg_data;
            end
            if (good) begin
                last_time_reg <= s_tdata[39:8];
                frames_reg <= frames_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

`include "crsf_rc_channel_receiver_assert.svh"

    `CRSF_ASSERT_IMP(a_idle_when_ready, aclk, aresetn, s_tready, !busy)
    `CRSF_ASSERT_IMP(a_last_channel, aclk, aresetn,
                     m_tvalid && m_tuser == KIND_CHANNEL && m_tlast, m_tdata[3:0] == CH_LAST)
    `CRSF_ASSERT_IMP(a_status_clean, aclk, aresetn,
                     m_tvalid && m_tuser == KIND_STATUS, m_tdata[25:0] == 26'd0 && m_tlast)
    `CRSF_ASSERT_NXT(a_good_starts, aclk, aresetn, good, busy && !s_tready)
endmodule

>>> verif/tb_crsf_rc_channel_receiver.sv
`timescale 1ns / 1ps

module tb_crsf_rc_channel_receiver;
    import crsf_pkg::*;

    localparam int MAXF = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [7:0] CFG_SPARE = 8'd2;
    localparam int N_ITEMS = 380;

    typedef struct {
        logic        kind;
        logic [3:0]  idx;
        logic [10:0] raw;
        logic [10:0] us;
        logic        alive;
        logic [31:0] count;
        logic        last;
    } chan_word_t;

    typedef struct {
        logic        req;
        logic [7:0]  b;
        logic [31:0] now;
        logic        typed;
        logic        exp_alive;
        logic [31:0] exp_count;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    crsf_rc_channel_receiver dut (.*);

    // predictor state
    logic [8:0]  gain;
    logic [31:0] timeout_ms;
    phase_t      rx_phase;
    logic [7:0]  rx_len;
    logic [7:0]  rx_pos;
    logic [7:0]  rx_buf [MAXF];
    logic [63:0] stage1 [16];
    logic [63:0] stage2 [16];
    logic [31:0] last_good_ms;
    logic [31:0] good_count;

    chan_word_t expected_words[$];
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    bit no_idle = 0;
    logic [31:0] clock_ms = 0;

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [7:0] crc_dvb(input int n);
        logic [7:0] c;
        c = 8'd0;
        for (int i = 0; i < n; i++) begin
            c = c ^ rx_buf[i];
            for (int k = 0; k < 8; k++)
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [10:0] raw_to_pulse(input logic [10:0] v);
        logic [31:0] c;
        c = v < RAW_MIN ? RAW_MIN : (v > RAW_MAX ? RAW_MAX : v);
        return 11'(1000 + ((c - 172) * 1000) / 1639);
    endfunction

    task automatic predictor_reset();
        gain = 9'd64;
        timeout_ms = 32'd500;
        rx_phase = P_ADDR;
        rx_len = 0;
        rx_pos = 0;
        for (int i = 0; i < 16; i++) begin
            stage1[i] = 64'd1500 << 8;
            stage2[i] = 64'd1500 << 8;
        end
        last_good_ms = 0;
        good_count = 0;
    endtask

    task automatic unpack_and_filter(input logic [31:0] now);
        logic [175:0] pl;
        logic [63:0] a, a2, s;
        chan_word_t w;
        for (int i = 0; i < 22; i++) pl[i*8 +: 8] = rx_buf[1 + i];
        a = gain > GAIN_ONE ? 64'd256 : 64'(gain);
        a2 = a * 2 > 256 ? 64'd256 : a * 2;
        for (int ch = 0; ch < 16; ch++) begin
            w.kind = KIND_CHANNEL;
            w.idx = 4'(ch);
            w.raw = pl[ch*11 +: 11];
            s = 64'(raw_to_pulse(w.raw)) << 8;
            stage1[ch] = (stage1[ch] * (256 - a) + s * a + 128) >> 8;
            stage2[ch] = (stage2[ch] * (256 - a2) + stage1[ch] * a2 + 128) >> 8;
            w.us = 11'((stage2[ch] + 128) >> 8);
            w.alive = 0;
            w.count = 0;
            w.last = (ch == 15);
            expected_words.push_back(w);
        end
        last_good_ms = now;
        good_count = good_count + 1;
    endtask

    task automatic crsf_predict(input logic req, input logic [7:0] b, input logic [31:0] now);
        chan_word_t w;
        if (req) begin
            w = '{KIND_STATUS, 0, 0, 0, 0, good_count, 1'b1};
            w.alive = (good_count != 0) && ((now - last_good_ms) < timeout_ms);
            expected_words.push_back(w);
        end else if (rx_phase == P_LEN) begin
            rx_len = b;
            if (b < LEN_MIN || b > MAXF - 2) begin
                rx_phase = P_ADDR;
            end else begin
                rx_pos = 0;
                rx_phase = P_BODY;
            end
        end else if (rx_phase == P_BODY) begin
            rx_buf[rx_pos] = b;
            rx_pos = rx_pos + 1;
            if (rx_pos >= rx_len) begin
                rx_phase = P_ADDR;
                if (crc_dvb(rx_len - 1) == rx_buf[rx_len - 1] && rx_buf[0] == RC_TYPE
                        && rx_len == RC_LEN)
                    unpack_and_filter(now);
            end
        end else begin
            rx_phase = (b == ADDR_FC || b == ADDR_TX || b == ADDR_BCAST) ? P_LEN : P_ADDR;
        end
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_word(input logic req, input logic [7:0] b, input logic [31:0] now,
                             input bit typed = 0, input logic t_alive = 0,
                             input logic [31:0] t_count = 0);
        chan_word_t w;
        int n;
        s_tuser = req;
        s_tdata = {now, b};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = expected_words.size();
        crsf_predict(req, b, now);
        if (typed && req) begin
            w = expected_words[n];
            w.alive = t_alive;
            w.count = t_count;
            expected_words[n] = w;
        end
        items_sent++;
        @(negedge aclk);
        n = draw_gap();
        if (n > 0) begin
            s_tvalid = 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic logic [31:0] next_now();
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 400);
        return clock_ms;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 24) == 0) send_word(1'b1, $urandom, next_now());
        send_word(1'b0, b, next_now());
    endtask

    // flavor: 0 good rc, 1 bad crc, 2 other type, 3 rc type wrong length,
    // 4 bad length byte, 5 noise
    task automatic send_frame(input int flavor, input int fill = -1);
        logic [7:0] fb [MAXF];
        logic [175:0] pl;
        logic [7:0] addr, len, c;
        logic [10:0] v;
        case ($urandom_range(0, 2))
            0: addr = ADDR_FC;
            1: addr = ADDR_TX;
            default: addr = ADDR_BCAST;
        endcase
        if (flavor == 5) begin
            repeat ($urandom_range(1, 6)) send_byte($urandom);
            return;
        end
        if (flavor == 4) begin
            send_byte(addr);
            send_byte($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(63, 255));
            return;
        end
        len = flavor == 2 ? $urandom_range(2, 30) :
              flavor == 3 ? ($urandom_range(0, 1) ? 8'd23 : 8'd25) : RC_LEN;
        for (int ch = 0; ch < 16; ch++) begin
            case ($urandom_range(0, 9))
                0: v = 0;
                1: v = 11'd2047;
                2: v = RAW_MIN - $urandom_range(0, 1);
                3: v = RAW_MAX + $urandom_range(0, 1);
                default: v = $urandom;
            endcase
            pl[ch*11 +: 11] = fill >= 0 ? 11'(fill) : v;
        end
        fb[0] = flavor == 2 ? 8'($urandom_range(0, 255)) : RC_TYPE;
        if (flavor == 2 && fb[0] == RC_TYPE) fb[0] = 8'h17;
        for (int i = 1; i < len - 1; i++)
            fb[i] = i <= 22 ? pl[(i-1)*8 +: 8] : 8'($urandom);
        c = 0;
        for (int i = 0; i < len - 1; i++) begin
            c = c ^ fb[i];
            for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        fb[len - 1] = flavor == 1 ? c ^ 8'(1 << $urandom_range(0, 7)) : c;
        send_byte(addr);
        send_byte(len);
        for (int i = 0; i < len; i++) send_byte(fb[i]);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ALPHA) gain = val[8:0];
        else if (idx == CFG_TIMEOUT) timeout_ms = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // result side: random stalls per word
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        chan_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (m_tuser !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, m_tuser); errors++;
                end
                if (m_tdata[3:0] !== e.idx) begin
                    $display("%0t: index exp %0d got %0d", $time, e.idx, m_tdata[3:0]); errors++;
                end
                if (m_tdata[14:4] !== e.raw) begin
                    $display("%0t: raw exp %0d got %0d", $time, e.raw, m_tdata[14:4]); errors++;
                end
                if (m_tdata[25:15] !== e.us) begin
                    $display("%0t: us exp %0d got %0d", $time, e.us, m_tdata[25:15]); errors++;
                end
                if (m_tdata[26] !== e.alive) begin
                    $display("%0t: alive exp %0d got %0d", $time, e.alive, m_tdata[26]); errors++;
                end
                if (m_tdata[58:27] !== e.count) begin
                    $display("%0t: count exp %0d got %0d", $time, e.count, m_tdata[58:27]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last exp %0d got %0d", $time, e.last, m_tlast); errors++;
                end
            end
        end
    end

    stim_row_t directed[] = '{
        '{1, 8'h00, 32'd0,        1, 0, 0},
        '{0, 8'hC8, 32'd1,        0, 0, 0},
        '{0, 8'h01, 32'd2,        0, 0, 0},
        '{0, 8'hEA, 32'd3,        0, 0, 0},
        '{0, 8'hFF, 32'd4,        0, 0, 0},
        '{0, 8'h00, 32'd5,        0, 0, 0},
        '{0, 8'd63, 32'd6,        0, 0, 0},
        '{0, 8'h55, 32'd7,        0, 0, 0},
        '{0, 8'hC8, 32'd8,        0, 0, 0},
        '{0, 8'd2,  32'd9,        0, 0, 0},
        '{0, 8'h00, 32'd10,       0, 0, 0},
        '{0, 8'h00, 32'd11,       0, 0, 0},
        '{0, 8'hFF, 32'hFFFFFFFF, 0, 0, 0},
        '{1, 8'hFF, 32'hFFFFFFFF, 1, 0, 0}
    };

    initial begin
        logic [8:0]  alphas [6] = '{9'd64, 9'd0, 9'd256, 9'd511, 9'd1, 9'd200};
        logic [31:0] limits [6] = '{32'd500, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd300, 32'd2000};
        int f;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        predictor_reset();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i])
            send_word(directed[i].req, directed[i].b, directed[i].now, directed[i].typed,
                      directed[i].exp_alive, directed[i].exp_count);
        send_frame(0, 0);
        send_frame(0, 2047);
        // same time stamp as the last frame byte, so the link is alive
        send_word(1'b1, 8'h00, clock_ms, 1, 1, 2);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain();
                write_reg(CFG_ALPHA, {$urandom} & ~32'h1FF | alphas[p]);
                write_reg(CFG_TIMEOUT, limits[p]);
                if (p == 3) write_reg(CFG_SPARE, $urandom);
            end
            no_idle = (p == 2);
            while (items_sent < N_ITEMS * (p + 1) / 6) begin
                f = $urandom_range(0, 19);
                send_frame(f < 12 ? 0 : f < 14 ? 1 : f < 15 ? 2 : f < 16 ? 3 : f < 17 ? 4 : 5);
                if ($urandom_range(0, 2) == 0) send_word(1'b1, $urandom, next_now());
            end
        end

        drain();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
